>>> rtl/core/brqm_pkg.sv
// Shared types and constants for the block ring queue manager.
// Used by brqm_core and block_ring_queue_manager; depends on nothing.
package brqm_pkg;

  localparam int OP_W      = 3;
  localparam int LEN_W     = 16;
  localparam int SLOT_W    = 4;
  localparam int STAT_W    = 3;
  localparam int SC_W      = 5;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_COMMIT  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd2;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ERROR   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTHING = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

  localparam logic [SC_W-1:0]  SLOT_COUNT_RESET = 5'd16;
  localparam logic [LEN_W-1:0] BLOCK_SIZE_RESET = 16'd64;

  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  len;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } fifo_wr_t;

endpackage

>>> rtl/core/block_ring_queue_manager.sv
// Block ring queue manager: a word accepted by the input register is decided in the
// core, and its result appears with done high from the result register; throughput
// is one word per cycle while busy is low, set by the input register, decision logic
// and result register in line. The receiver cannot stall: every result stands for
// exactly one cycle. Reset is synchronous: it restores the registers and empties the
// pool; busy is high while rst is high and in the cycle after it falls.
module block_ring_queue_manager #(
  parameter int SLOTS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [brqm_pkg::OP_W-1:0]      op,
  input  logic [brqm_pkg::LEN_W-1:0]     commit_length,
  output logic                           done,
  output logic [brqm_pkg::STAT_W-1:0]    status,
  output logic [brqm_pkg::SLOT_W-1:0]    block_slot,
  output logic [brqm_pkg::LEN_W-1:0]     block_length,
  input  logic                           wr_en,
  input  logic [brqm_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [brqm_pkg::CFG_W-1:0]     wr_data
);

  localparam int TOP    = (SLOTS < 16) ? SLOTS : 16;
  localparam int IDX_W  = $clog2(TOP);
  localparam int WORD_W = brqm_pkg::SLOT_W + brqm_pkg::LEN_W;

  brqm_pkg::item_t    item;
  brqm_pkg::result_t  res_next;
  brqm_pkg::fifo_wr_t fifo_wr;
  logic [IDX_W-1:0]            fifo_waddr;
  logic [IDX_W-1:0]            fifo_raddr;
  logic [brqm_pkg::SLOT_W-1:0] fifo_rslot;
  logic [brqm_pkg::LEN_W-1:0]  fifo_rlen;
  logic [WORD_W-1:0]           fifo_rdata;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      item.valid <= 1'b0;
    end else begin
      busy       <= 1'b0;
      item.valid <= start && !busy;
    end
    item.op  <= op;
    item.len <= commit_length;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    status       <= res_next.status;
    block_slot   <= res_next.slot;
    block_length <= res_next.len;
  end

  assign {fifo_rslot, fifo_rlen} = fifo_rdata;

  brqm_core #(
    .SLOTS(SLOTS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .item      (item),
    .res_next  (res_next),
    .fifo_wr   (fifo_wr),
    .fifo_waddr(fifo_waddr),
    .fifo_raddr(fifo_raddr),
    .fifo_rslot(fifo_rslot),
    .fifo_rlen (fifo_rlen)
  );

  brqm_fifo #(
    .WIDTH(WORD_W),
    .DEPTH(TOP)
  ) u_fifo (
    .clk  (clk),
    .we   (fifo_wr.we),
    .waddr(fifo_waddr),
    .wdata({fifo_wr.slot, fifo_wr.len}),
    .raddr(fifo_raddr),
    .rdata(fifo_rdata)
  );

endmodule

>>> rtl/core/brqm_fifo.sv
// Generic RAM: one write port and one read port with registered read data.
// Stands alone; holds the handoff FIFO words of block_ring_queue_manager.
module brqm_fifo #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/brqm_core.sv
// Pool state, configuration registers and the per-word decision logic.
// Depends on brqm_pkg; drives the handoff storage in brqm_fifo.
module brqm_core #(
  parameter int SLOTS = 16,
  localparam int TOP   = (SLOTS < 16) ? SLOTS : 16,
  localparam int IDX_W = $clog2(TOP)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [brqm_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [brqm_pkg::CFG_W-1:0]     wr_data,
  input  brqm_pkg::item_t                item,
  output brqm_pkg::result_t              res_next,
  output brqm_pkg::fifo_wr_t             fifo_wr,
  output logic [IDX_W-1:0]               fifo_waddr,
  output logic [IDX_W-1:0]               fifo_raddr,
  input  logic [brqm_pkg::SLOT_W-1:0]    fifo_rslot,
  input  logic [brqm_pkg::LEN_W-1:0]     fifo_rlen
);

  localparam int N_W = IDX_W + 1;

  logic [brqm_pkg::SC_W-1:0]  slot_count;
  logic [brqm_pkg::LEN_W-1:0] block_size;

  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic             producer_pending, producer_pending_next;
  logic [IDX_W-1:0] producer_slot, producer_slot_next;
  logic             consumer_pending, consumer_pending_next;
  logic [IDX_W-1:0] fifo_head, fifo_head_next;
  logic [IDX_W-1:0] fifo_tail, fifo_tail_next;
  logic [IDX_W-1:0] fifo_fill, fifo_fill_next;

  logic [brqm_pkg::SC_W-1:0] sat_count;
  logic [N_W-1:0]            ring_n;
  logic [IDX_W-1:0]          nm1;
  logic [IDX_W-1:0]          nm2;
  logic [IDX_W-1:0]          behind;

  logic [IDX_W-1:0]            fifo_head_d;
  logic                        fwd_hit;
  logic [brqm_pkg::SLOT_W-1:0] fwd_slot;
  logic [brqm_pkg::LEN_W-1:0]  fwd_len;
  logic [brqm_pkg::SLOT_W-1:0] hand_slot;
  logic [brqm_pkg::LEN_W-1:0]  hand_len;

  // saturate the ring size into 2..TOP
  always_comb begin
    if (slot_count < 5'd2) begin
      sat_count = 5'd2;
    end else if (slot_count > brqm_pkg::SC_W'(TOP)) begin
      sat_count = brqm_pkg::SC_W'(TOP);
    end else begin
      sat_count = slot_count;
    end
  end

  assign ring_n = N_W'(sat_count);
  assign nm1    = IDX_W'(ring_n - N_W'(1));
  assign nm2    = IDX_W'(ring_n - N_W'(2));
  assign behind = (read_index == '0) ? nm1 : IDX_W'(read_index - 1'b1);

  // read ahead at the head the coming edge will leave, so the word is ready next cycle
  always_comb begin
    if (rst) begin
      fifo_head_d = '0;
    end else if (wr_en) begin
      fifo_head_d = (wr_index == brqm_pkg::CFG_SLOT_COUNT) ? '0 : fifo_head;
    end else begin
      fifo_head_d = fifo_head_next;
    end
  end

  assign fifo_waddr = fifo_tail;
  assign fifo_raddr = fifo_head_d;

  // forward a commit that lands on the entry the RAM is reading in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= fifo_wr.we && (fifo_tail == fifo_head_d);
    end
    fwd_slot <= fifo_wr.slot;
    fwd_len  <= fifo_wr.len;
  end

  assign hand_slot = fwd_hit ? fwd_slot : fifo_rslot;
  assign hand_len  = fwd_hit ? fwd_len : fifo_rlen;

  always_comb begin
    write_index_next      = write_index;
    read_index_next       = read_index;
    producer_pending_next = producer_pending;
    producer_slot_next    = producer_slot;
    consumer_pending_next = consumer_pending;
    fifo_head_next        = fifo_head;
    fifo_tail_next        = fifo_tail;
    fifo_fill_next        = fifo_fill;

    res_next.valid  = item.valid;
    res_next.status = brqm_pkg::ST_ERROR;
    res_next.slot   = '0;
    res_next.len    = '0;

    fifo_wr.we   = 1'b0;
    fifo_wr.slot = brqm_pkg::SLOT_W'(producer_slot);
    fifo_wr.len  = item.len;

    if (item.valid) begin
      case (item.op)
        brqm_pkg::OP_ALLOC: begin
          if (write_index == behind) begin
            res_next.status = brqm_pkg::ST_FULL;
          end else if (producer_pending) begin
            res_next.slot = brqm_pkg::SLOT_W'(producer_slot);
            res_next.len  = block_size;
          end else begin
            producer_pending_next = 1'b1;
            producer_slot_next    = write_index;
            res_next.slot         = brqm_pkg::SLOT_W'(write_index);
            res_next.len          = block_size;
            write_index_next      = (write_index == nm1) ? '0 : IDX_W'(write_index + 1'b1);
            res_next.status       = brqm_pkg::ST_OK;
          end
        end
        brqm_pkg::OP_COMMIT: begin
          if (producer_pending && item.len <= block_size && fifo_fill < nm1) begin
            fifo_wr.we            = 1'b1;
            fifo_tail_next        = (fifo_tail == nm2) ? '0 : IDX_W'(fifo_tail + 1'b1);
            fifo_fill_next        = IDX_W'(fifo_fill + 1'b1);
            producer_pending_next = 1'b0;
            res_next.status       = brqm_pkg::ST_OK;
          end
        end
        brqm_pkg::OP_DEQUEUE: begin
          if (consumer_pending) begin
            res_next.status = brqm_pkg::ST_ERROR;
          end else if (fifo_fill == '0) begin
            res_next.status = brqm_pkg::ST_NOTHING;
          end else begin
            res_next.slot  = hand_slot;
            res_next.len   = hand_len;
            fifo_head_next = (fifo_head == nm2) ? '0 : IDX_W'(fifo_head + 1'b1);
            fifo_fill_next = IDX_W'(fifo_fill - 1'b1);
            // drop the pair without a consumer slot if block size shrank below it
            if (hand_len <= block_size) begin
              consumer_pending_next = 1'b1;
              res_next.status       = brqm_pkg::ST_OK;
            end
          end
        end
        brqm_pkg::OP_RELEASE: begin
          if (consumer_pending) begin
            consumer_pending_next = 1'b0;
            if (write_index == read_index) begin
              res_next.status = brqm_pkg::ST_EMPTY;
            end else begin
              read_index_next = (read_index == nm1) ? '0 : IDX_W'(read_index + 1'b1);
              res_next.status = brqm_pkg::ST_OK;
            end
          end
        end
        brqm_pkg::OP_CLEAR: begin
          write_index_next      = '0;
          read_index_next       = '0;
          producer_pending_next = 1'b0;
          producer_slot_next    = '0;
          consumer_pending_next = 1'b0;
          fifo_head_next        = '0;
          fifo_tail_next        = '0;
          fifo_fill_next        = '0;
          res_next.status       = brqm_pkg::ST_OK;
        end
        default: begin
          res_next.status = brqm_pkg::ST_ERROR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count       <= brqm_pkg::SLOT_COUNT_RESET;
      block_size       <= brqm_pkg::BLOCK_SIZE_RESET;
      write_index      <= '0;
      read_index       <= '0;
      producer_pending <= 1'b0;
      producer_slot    <= '0;
      consumer_pending <= 1'b0;
      fifo_head        <= '0;
      fifo_tail        <= '0;
      fifo_fill        <= '0;
    end else if (wr_en) begin
      if (wr_index == brqm_pkg::CFG_SLOT_COUNT) begin
        // a new ring size empties the pool
        slot_count       <= wr_data[brqm_pkg::SC_W-1:0];
        write_index      <= '0;
        read_index       <= '0;
        producer_pending <= 1'b0;
        producer_slot    <= '0;
        consumer_pending <= 1'b0;
        fifo_head        <= '0;
        fifo_tail        <= '0;
        fifo_fill        <= '0;
      end else begin
        block_size <= wr_data;
      end
    end else begin
      write_index      <= write_index_next;
      read_index       <= read_index_next;
      producer_pending <= producer_pending_next;
      producer_slot    <= producer_slot_next;
      consumer_pending <= consumer_pending_next;
      fifo_head        <= fifo_head_next;
      fifo_tail        <= fifo_tail_next;
      fifo_fill        <= fifo_fill_next;
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst) fifo_fill <= nm1)
    else $error("handoff fifo count exceeds ring depth");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (N_W'(write_index) < ring_n) && (N_W'(read_index) < ring_n))
    else $error("ring index outside ring");

  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    (item.valid && !wr_en && item.op == brqm_pkg::OP_COMMIT
     && res_next.status == brqm_pkg::ST_OK)
    |=> (!producer_pending && fifo_fill == IDX_W'($past(fifo_fill) + 1'b1)))
    else $error("commit did not hand the slot off");

  a_dequeue_ok: assert property (@(posedge clk) disable iff (rst)
    (item.valid && !wr_en && item.op == brqm_pkg::OP_DEQUEUE
     && res_next.status == brqm_pkg::ST_OK) |=> consumer_pending)
    else $error("dequeue did not mark a consumer slot");

endmodule
